// ===== hw/rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

	// Header is a 2-byte id followed by a 4-byte length.
	localparam int unsigned HEADER_BYTES = 6;
	localparam int unsigned HDR_SHIFT_W  = 8 * (HEADER_BYTES - 1);

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned OUT_DATA_W = 64;

	// Register indexes of the configuration port.
	localparam logic CFG_MAX_LENGTH   = 1'b0;
	localparam logic CFG_HEARTBEAT_ID = 1'b1;

	localparam logic [31:0] MAX_LENGTH_RESET   = 32'd1048576;
	localparam logic [15:0] HEARTBEAT_ID_RESET = 16'd0;

	// Input operation codes.
	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_HEARTBEAT = 2'd1,
		KIND_TOO_LARGE = 2'd2,
		KIND_EMPTY     = 2'd3
	} kind_t;

	// One accepted input item.
	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] message_id;
		logic [7:0]  payload_byte;
		logic        first_flag;
		logic        last_flag;
		logic [31:0] frame_length;
	} result_t;

endpackage

// ===== hw/rtl/lpd_in_stage.sv =====
// ----------------------------------------------------------------------------
// lpd_in_stage
// Deframer input; takes one item per cycle unless output stalls.
// ----------------------------------------------------------------------------
module lpd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_tuser,   // op
	input  logic [7:0]        s_tdata,   // data_byte
	input  logic              advance,
	output logic              valid_s1,
	output lpd_pkg::in_item_t item_s1
);
	import lpd_pkg::*;

	// The register can load whenever it is empty or its item moves on.
	assign s_tready = !valid_s1 || advance;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op        <= s_tuser;
			item_s1.data_byte <= s_tdata;
		end
	end

endmodule

// ===== hw/rtl/lpd_parser.sv =====
// ----------------------------------------------------------------------------
// lpd_parser
// Header and payload parser: holds the framing state and forms the result.
// ----------------------------------------------------------------------------
module lpd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  lpd_pkg::in_item_t item,
	input  logic [31:0]       max_length,
	input  logic [15:0]       heartbeat_id,
	output logic              res_valid,
	output lpd_pkg::result_t  res
);
	import lpd_pkg::*;

	logic [2:0]             header_count_q;
	logic [HDR_SHIFT_W-1:0] header_shift_q;
	logic [15:0]            current_id_q;
	logic [31:0]            current_length_q;
	logic [31:0]            remaining_q;
	logic                   in_payload_q;
	logic                   halted_q;

	logic [2:0]             header_count_d;
	logic [HDR_SHIFT_W-1:0] header_shift_d;
	logic [15:0]            current_id_d;
	logic [31:0]            current_length_d;
	logic [31:0]            remaining_d;
	logic                   in_payload_d;
	logic                   halted_d;

	logic [15:0] hdr_id;
	logic [31:0] hdr_len;
	logic        last;

	// Fields of the complete header once the final length byte arrives.
	assign hdr_id  = header_shift_q[HDR_SHIFT_W-1 -: 16];
	assign hdr_len = {header_shift_q[23:0], item.data_byte};
	assign last    = (remaining_q == 32'd1);

	// Next state and result for the item in the input register.
	always_comb begin
		header_count_d   = header_count_q;
		header_shift_d   = header_shift_q;
		current_id_d     = current_id_q;
		current_length_d = current_length_q;
		remaining_d      = remaining_q;
		in_payload_d     = in_payload_q;
		halted_d         = halted_q;
		res_valid        = 1'b0;
		res.kind         = KIND_PAYLOAD;
		res.message_id   = current_id_q;
		res.payload_byte = 8'd0;
		res.first_flag   = 1'b0;
		res.last_flag    = 1'b0;
		res.frame_length = current_length_q;

		if (item.op == OP_FLUSH) begin
			header_count_d   = 3'd0;
			header_shift_d   = '0;
			current_id_d     = 16'd0;
			current_length_d = 32'd0;
			remaining_d      = 32'd0;
			in_payload_d     = 1'b0;
			halted_d         = 1'b0;
		end else if (halted_q) begin
			// Bytes are dropped until a flush.
		end else if (!in_payload_q) begin
			if (header_count_q < 3'(HEADER_BYTES - 1)) begin
				header_shift_d = {header_shift_q[HDR_SHIFT_W-9:0], item.data_byte};
				header_count_d = header_count_q + 3'd1;
			end else begin
				header_count_d   = 3'd0;
				header_shift_d   = '0;
				current_id_d     = hdr_id;
				current_length_d = hdr_len;
				res.message_id   = hdr_id;
				res.frame_length = hdr_len;
				if (hdr_len > max_length) begin
					halted_d  = 1'b1;
					res_valid = 1'b1;
					res.kind  = KIND_TOO_LARGE;
				end else if (hdr_len == 32'd0) begin
					halted_d  = 1'b1;
					res_valid = 1'b1;
					res.kind  = KIND_EMPTY;
				end else begin
					remaining_d  = hdr_len;
					in_payload_d = 1'b1;
				end
			end
		end else begin
			remaining_d = remaining_q - 32'd1;
			if (last) begin
				in_payload_d = 1'b0;
			end
			if (current_id_q == heartbeat_id) begin
				// Heartbeats are swallowed; one result marks the end.
				res_valid = last;
				res.kind  = KIND_HEARTBEAT;
			end else begin
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = item.data_byte;
				res.first_flag   = (remaining_q == current_length_q);
				res.last_flag    = last;
			end
		end
	end

	// Control state of the parser.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= 3'd0;
			in_payload_q   <= 1'b0;
			halted_q       <= 1'b0;
			remaining_q    <= 32'd0;
		end else if (step) begin
			header_count_q <= header_count_d;
			in_payload_q   <= in_payload_d;
			halted_q       <= halted_d;
			remaining_q    <= remaining_d;
		end
	end

	// Header and message registers; cleared on reset to match a flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_shift_q   <= '0;
			current_id_q     <= 16'd0;
			current_length_q <= 32'd0;
		end else if (step) begin
			header_shift_q   <= header_shift_d;
			current_id_q     <= current_id_d;
			current_length_q <= current_length_d;
		end
	end

	// A halted parser never sits inside a payload.
	a_halt_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !in_payload_q)
		else $error("parser halted inside a payload");

	// The header counter stays below the header length.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		header_count_q < 3'(HEADER_BYTES))
		else $error("header count out of range");

	// Inside a payload at least one byte is still due.
	a_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (remaining_q != 32'd0 && remaining_q <= current_length_q))
		else $error("payload byte count inconsistent");

endmodule

// ===== hw/rtl/length_prefixed_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Each item waits in the input register until the output register is free.
// Throughput: one input item per cycle, held up only by m_tready stalls.
// The rate is set by the combinational parser step between input and output
// registers. Reset (arst_n low) clears the parser and sets max_length to
// 1048576 and heartbeat_id to 0.
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top
// Splits id/length messages into payload, heartbeat and length-error results.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic                           s_tuser,   // op
	input  logic [7:0]                     s_tdata,   // data_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [1:0]                     m_tuser,   // kind
	output logic                           m_tlast,   // last_flag
	// message_id[15:0], payload_byte[23:16], first_flag[24], frame_length[56:25]
	output logic [lpd_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lpd_pkg::*;

	logic        max_length_q;
	logic [31:0] max_length_val_q;
	logic [15:0] heartbeat_id_q;
	logic        valid_s1;
	in_item_t    item_s1;
	logic        advance;
	logic        res_valid;
	result_t     res;
	result_t     out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_val_q <= MAX_LENGTH_RESET;
			heartbeat_id_q   <= HEARTBEAT_ID_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_LENGTH:   max_length_val_q <= cfg_data[31:0];
				CFG_HEARTBEAT_ID: heartbeat_id_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Flag that a max_length write has been seen since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= 1'b0;
		end else if (cfg_we && cfg_index == CFG_MAX_LENGTH) begin
			max_length_q <= 1'b1;
		end
	end

	// The input item moves on when the output register is free.
	assign advance = valid_s1 && (!m_tvalid || m_tready);

	lpd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lpd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.item         (item_s1),
		.max_length   (max_length_val_q),
		.heartbeat_id (heartbeat_id_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= res_valid;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tuser = out_q.kind;
	assign m_tlast = out_q.last_flag;
	assign m_tdata = {7'd0, out_q.frame_length, out_q.first_flag,
		out_q.payload_byte, out_q.message_id};

	// A result that is stalled stays presented in the next cycle.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("output result dropped under stall");

	// Only payload results carry first or last marks.
	a_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tlast || m_tdata[24])) |-> (m_tuser == KIND_PAYLOAD))
		else $error("first or last mark on a non-payload result");

	// Once written, max_length holds its value until the next write.
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(max_length_q && !cfg_we) |=> $stable(max_length_val_q))
		else $error("max_length changed without a write");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed deframer. Framed byte streams
// (id, length, payload), heartbeats, bad lengths, flushes and noise go in
// through the slave stream. A local model of the parser predicts every
// result, and each result taken from the master stream is compared field
// by field with the oldest prediction. Both streams stall at random, and
// the two limit registers are changed between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lpd_pkg::*;

	localparam int unsigned IDLE_PCT     = 33;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned PRINT_LIMIT  = 100;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic                  s_tuser   = OP_DATA;
	logic [7:0]            s_tdata   = 8'h00;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic                  cfg_index = CFG_MAX_LENGTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Run without any idling on either side while set.
	bit steady = 1'b0;

	// Model state and its copy of the registers.
	logic [31:0] max_len_reg;
	logic [15:0] hb_id_reg;
	logic [2:0]  hdr_count;
	logic [39:0] hdr_shift;
	logic [15:0] cur_id;
	logic [31:0] cur_len;
	logic [31:0] remaining;
	bit          in_payload;
	bit          halted;

	result_t     pending_results[$];

	int unsigned cycle_count     = 0;
	int unsigned mismatch_count  = 0;
	int unsigned items_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned payload_seen    = 0;
	int unsigned heartbeat_seen  = 0;
	int unsigned error_seen      = 0;
	int unsigned settings_used   = 1;

	length_prefixed_deframer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Cycle counter that stops a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Clears the parser part of the model; registers are kept.
	function automatic void clear_parser();
		hdr_count  = '0;
		hdr_shift  = '0;
		cur_id     = '0;
		cur_len    = '0;
		remaining  = '0;
		in_payload = 1'b0;
		halted     = 1'b0;
	endfunction

	function automatic void push_result(kind_t kind, logic [15:0] id, logic [7:0] data,
		logic first, logic last, logic [31:0] len);
		result_t r;
		r.kind         = kind;
		r.message_id   = id;
		r.payload_byte = data;
		r.first_flag   = first;
		r.last_flag    = last;
		r.frame_length = len;
		pending_results.push_back(r);
	endfunction

	// Advances the model by one accepted item and queues the result it causes.
	function automatic void deframe_byte(logic op, logic [7:0] data);
		logic [15:0] id;
		logic [31:0] len;
		logic        first;
		logic        last;
		if (op == OP_FLUSH) begin
			clear_parser();
			return;
		end
		if (halted)
			return;
		if (!in_payload) begin
			if (hdr_count + 1 < HEADER_BYTES) begin
				hdr_shift = {hdr_shift[31:0], data};
				hdr_count = hdr_count + 3'd1;
				return;
			end
			id        = hdr_shift[39:24];
			len       = {hdr_shift[23:0], data};
			hdr_count = '0;
			hdr_shift = '0;
			cur_id    = id;
			cur_len   = len;
			// The too-large test comes before the empty test.
			if (len > max_len_reg) begin
				halted = 1'b1;
				push_result(KIND_TOO_LARGE, id, 8'h00, 1'b0, 1'b0, len);
			end else if (len == 0) begin
				halted = 1'b1;
				push_result(KIND_EMPTY, id, 8'h00, 1'b0, 1'b0, len);
			end else begin
				remaining  = len;
				in_payload = 1'b1;
			end
			return;
		end
		first     = (remaining == cur_len);
		remaining = remaining - 32'd1;
		last      = (remaining == 0);
		if (last)
			in_payload = 1'b0;
		if (cur_id == hb_id_reg) begin
			if (last)
				push_result(KIND_HEARTBEAT, cur_id, 8'h00, 1'b0, 1'b0, cur_len);
		end else begin
			push_result(KIND_PAYLOAD, cur_id, data, first, last, cur_len);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] exp_val,
		input logic [63:0] got_val);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("Mismatch at result %0d, %s: expected %0h, got %0h",
				results_checked, what, exp_val, got_val);
	endtask

	// Result side: random stalls, and each accepted item checked in order.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			m_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", 64'd0, m_tdata);
				end else begin
					exp_r = pending_results.pop_front();
					if (m_tuser !== exp_r.kind)
						report_mismatch("kind", 64'(exp_r.kind), 64'(m_tuser));
					if (m_tdata[15:0] !== exp_r.message_id)
						report_mismatch("message_id", 64'(exp_r.message_id),
							64'(m_tdata[15:0]));
					if (m_tdata[23:16] !== exp_r.payload_byte)
						report_mismatch("payload_byte", 64'(exp_r.payload_byte),
							64'(m_tdata[23:16]));
					if (m_tdata[24] !== exp_r.first_flag)
						report_mismatch("first_flag", 64'(exp_r.first_flag),
							64'(m_tdata[24]));
					if (m_tlast !== exp_r.last_flag)
						report_mismatch("last_flag", 64'(exp_r.last_flag), 64'(m_tlast));
					if (m_tdata[56:25] !== exp_r.frame_length)
						report_mismatch("frame_length", 64'(exp_r.frame_length),
							64'(m_tdata[56:25]));
					if (m_tdata[63:57] !== 7'd0)
						report_mismatch("tdata padding", 64'd0, 64'(m_tdata[63:57]));
					case (exp_r.kind)
						KIND_PAYLOAD:   payload_seen++;
						KIND_HEARTBEAT: heartbeat_seen++;
						default:        error_seen++;
					endcase
				end
				results_checked++;
			end
		end
	end

	// Sends one item; returns at the edge where it was accepted.
	task automatic send_item(input logic op, input logic [7:0] data);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		deframe_byte(op, data);
		items_sent++;
	endtask

	task automatic send_flush();
		logic [7:0] junk;
		junk = 8'($urandom);
		send_item(OP_FLUSH, junk);
	endtask

	task automatic send_random_byte();
		logic [7:0] data;
		data = 8'($urandom);
		send_item(OP_DATA, data);
	endtask

	// Holds the input side idle until every predicted result has arrived.
	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Full idle: results drained, then the parser's own latency waited out.
	task automatic wait_idle();
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers; only called while the block is idle.
	task automatic set_limits(input logic [31:0] max_len, input logic [15:0] hb_id);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_LENGTH;
		cfg_data  <= max_len;
		@(posedge clk);
		cfg_index <= CFG_HEARTBEAT_ID;
		cfg_data  <= {16'd0, hb_id};
		@(posedge clk);
		cfg_we    <= 1'b0;
		max_len_reg = max_len;
		hb_id_reg   = hb_id;
		settings_used++;
		@(posedge clk);
	endtask

	task automatic send_header(input logic [15:0] id, input logic [31:0] len);
		logic [47:0] hdr;
		hdr = {id, len};
		for (int i = 5; i >= 0; i--)
			send_item(OP_DATA, hdr[i*8 +: 8]);
	endtask

	// A whole message; a bad length is followed by up to three dropped bytes and a flush.
	task automatic send_frame(input logic [15:0] id, input logic [31:0] len);
		send_header(id, len);
		if (len == 0 || len > max_len_reg) begin
			repeat ($urandom_range(3)) send_random_byte();
			send_flush();
		end else begin
			for (int unsigned k = 0; k < len; k++)
				send_random_byte();
		end
	endtask

	function automatic logic [31:0] pick_good_len();
		logic [31:0] cap;
		cap = ($urandom_range(9) == 0) ? 32'd200 : 32'd12;
		if (max_len_reg < cap)
			cap = max_len_reg;
		if (cap == 0)
			return 32'd0;
		return $urandom_range(cap, 1);
	endfunction

	function automatic logic [31:0] pick_bad_len();
		logic [31:0] len;
		len = $urandom;
		if ($urandom_range(1) == 0 || len <= max_len_reg)
			len = max_len_reg + 32'd1;
		return len;
	endfunction

	// A message followed by a flush that may cut it in its header or in its payload.
	task automatic send_cut_frame();
		logic [15:0]  id;
		logic [31:0]  len;
		logic [47:0]  hdr;
		int unsigned  cut;
		id  = 16'($urandom);
		len = ($urandom_range(3) == 0) ? $urandom : pick_good_len();
		hdr = {id, len};
		cut = $urandom_range(6 + ((len > 32) ? 32 : len), 1);
		for (int unsigned i = 0; i < cut; i++) begin
			if (i < 6)
				send_item(OP_DATA, hdr[(5 - i)*8 +: 8]);
			else
				send_random_byte();
		end
		send_flush();
	endtask

	// Directed: payload extremes, one-byte heartbeat, both errors, halted bytes.
	task automatic test_basic_frames();
		send_header(16'h1234, 32'd2);
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'hFF);
		send_header(hb_id_reg, 32'd1);
		send_item(OP_DATA, 8'hA5);
		send_header(16'hFFFF, 32'd0);
		send_item(OP_DATA, 8'h5A);
		send_item(OP_FLUSH, 8'hFF);
		send_header(16'hFFFF, 32'hFFFF_FFFF);
		send_item(OP_FLUSH, 8'h00);
		wait_idle();
	endtask

	// A zero limit: every length is either empty or too large.
	task automatic test_zero_limit();
		set_limits(32'd0, 16'hFFFF);
		send_frame(16'h0001, 32'd0);
		send_frame(16'h0001, 32'd1);
		send_frame(16'hFFFF, 32'd0);
		wait_idle();
	endtask

	// A one-byte limit, with a heartbeat at the limit and a length just above.
	task automatic test_one_byte_limit();
		set_limits(32'd1, 16'h8000);
		send_frame(16'h8000, 32'd1);
		send_frame(16'h0042, 32'd1);
		send_frame(16'h0042, 32'd2);
		wait_idle();
	endtask

	// Flushes in the middle of a header and of a payload, then a clean message.
	task automatic test_flush_mid_message();
		set_limits(MAX_LENGTH_RESET, HEARTBEAT_ID_RESET);
		send_item(OP_DATA, 8'h12);
		send_item(OP_DATA, 8'h34);
		send_item(OP_DATA, 8'h00);
		send_flush();
		send_header(16'h0777, 32'd5);
		send_random_byte();
		send_random_byte();
		send_flush();
		send_frame(16'h0777, 32'd3);
		wait_idle();
	endtask

	// Random traffic under one register setting; mostly well-formed messages.
	task automatic test_random_traffic(input logic [31:0] max_len, input logic [15:0] hb_id,
		input int unsigned count, input bit no_idle, input bit mid_pause);
		int unsigned target;
		int unsigned half;
		int unsigned choice;
		set_limits(max_len, hb_id);
		steady = no_idle;
		target = items_sent + count;
		half   = items_sent + count / 2;
		while (items_sent < target) begin
			choice = $urandom_range(99);
			if (choice < 65)
				send_frame(16'($urandom), pick_good_len());
			else if (choice < 77)
				send_frame(hb_id_reg, pick_good_len());
			else if (choice < 82)
				send_frame(16'($urandom), 32'd0);
			else if (choice < 89 && max_len_reg != 32'hFFFF_FFFF)
				send_frame(16'($urandom), pick_bad_len());
			else if (choice < 95)
				send_cut_frame();
			else begin
				repeat ($urandom_range(8, 1)) send_random_byte();
				send_flush();
			end
			if (mid_pause && items_sent >= half) begin
				mid_pause = 1'b0;
				wait_results();
			end
		end
		wait_idle();
		steady = 1'b0;
	endtask

	initial begin
		max_len_reg = MAX_LENGTH_RESET;
		hb_id_reg   = HEARTBEAT_ID_RESET;
		clear_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_zero_limit();
		test_one_byte_limit();
		test_flush_mid_message();
		test_random_traffic(MAX_LENGTH_RESET, HEARTBEAT_ID_RESET, 300, 1'b0, 1'b0);
		test_random_traffic(32'd8, 16'hFFFF, 250, 1'b0, 1'b1);
		test_random_traffic(32'hFFFF_FFFF, 16'($urandom), 250, 1'b1, 1'b0);
		test_random_traffic($urandom_range(300, 1), 16'($urandom), 300, 1'b0, 1'b0);

		if (pending_results.size() != 0)
			report_mismatch("results never received", 64'(pending_results.size()), 64'd0);
		$display("Sent %0d items under %0d register settings; checked %0d results.",
			items_sent, settings_used, results_checked);
		$display("Results seen: %0d payload bytes, %0d heartbeats, %0d length errors.",
			payload_seen, heartbeat_seen, error_seen);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_in_stage.sv
hw/rtl/lpd_parser.sv
hw/rtl/length_prefixed_deframer_top.sv
tb/tb_top.sv
